// File: rtl/core/bounded_jump_min_cost_dp_unit_defines.svh
// ----------------------------------------------------------------------------
// bounded jump min cost dp unit - assertion macros
// shared property wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef BOUNDED_JUMP_MIN_COST_DP_UNIT_DEFINES_SVH
`define BOUNDED_JUMP_MIN_COST_DP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// plain property, checked every clock outside reset
`define BJMC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bjmc assertion failed");

// same-cycle implication
`define BJMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bjmc implication failed");

// next-cycle implication
`define BJMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bjmc next-cycle implication failed");

`else

`define BJMC_ASSERT(lbl, clk, rst_n, prop)
`define BJMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BJMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/bjmc_pkg.sv
// ----------------------------------------------------------------------------
// bjmc_pkg
// shared types for the bounded jump min cost dp unit
// ----------------------------------------------------------------------------
`default_nettype none

package bjmc_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned COST_W = 16;
    localparam int unsigned BEST_W = 32;

    // one stored camp
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [BEST_W-1:0] best;
        logic              ok;
    } t_entry;

    // running minimum, travels forward as a query and back as a result
    typedef struct packed {
        logic              valid;
        logic [BEST_W-1:0] best;
        logic              found;
    } t_acc;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/bjmc_cell.sv
// ----------------------------------------------------------------------------
// bjmc_cell
// one stored camp plus the forward query and return result stages
// ----------------------------------------------------------------------------
`default_nettype none

module bjmc_cell import bjmc_pkg::*; #(
    parameter int unsigned IDX_W = 10,
    parameter int unsigned IDX   = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [POS_W-1:0]  i_pos,
    input  wire logic [POS_W-1:0]  i_max_jump,
    input  wire logic              i_base_ok,
    input  wire logic [IDX_W-1:0]  i_last_idx,
    input  wire logic              i_shift,
    input  wire t_entry            i_ent,
    output t_entry                 o_ent,
    input  wire t_acc              i_tok,
    output t_acc                   o_tok,
    input  wire t_acc              i_back,
    output t_acc                   o_back
);

    t_entry r_ent;
    t_acc   r_tok;
    t_acc   r_back;
    t_acc   n_back;

    logic   w_reach;
    logic   w_end;
    logic   w_take;
    t_acc   w_upd;
    t_acc   w_res;
    logic   w_done;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ent <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_back <= '0;
        end else begin
            r_tok  <= i_tok;
            r_back <= n_back;
        end
    end

    always_comb begin
        // negative distance counts as in reach, so compare pos <= stored + jump
        w_reach = ({1'b0, i_pos} <= ({1'b0, r_ent.pos} + {1'b0, i_max_jump}));
        w_end   = (i_last_idx == IDX_W'(IDX));
        w_take  = r_ent.ok && (!r_tok.found || (r_ent.best < r_tok.best));

        w_upd.valid = r_tok.valid;
        w_upd.best  = w_take ? r_ent.best : r_tok.best;
        w_upd.found = r_tok.found | r_ent.ok;

        w_res  = r_tok;
        w_done = 1'b0;
        o_tok  = '0;
        priority if (!w_reach) begin
            w_done = r_tok.valid;
            w_res  = r_tok;
        end else if (w_end) begin
            // oldest camp passed, the base camp is next in line
            w_done = r_tok.valid;
            w_res  = i_base_ok ? t_acc'{valid: 1'b1, best: '0, found: 1'b1} : w_upd;
        end else begin
            o_tok = w_upd;
        end
        w_res.valid = 1'b1;

        n_back = w_done ? w_res : i_back;
    end

    assign o_back = r_back;
    assign o_ent  = r_ent;

endmodule

`default_nettype wire

// File: rtl/core/bounded_jump_min_cost_dp_unit.sv
// ----------------------------------------------------------------------------
// bounded_jump_min_cost_dp_unit
// streaming minimum cost path over camps with a bounded jump length
// ----------------------------------------------------------------------------
// camp channel: i_camp_valid / o_camp_stall carries position, cost and a last
// flag. result channel: o_result_valid / i_result_stall carries best cost,
// reachable, overflow and the echoed last flag, one result per camp.
// max_jump is written through i_max_jump_we / i_max_jump_wdata; the user
// must write it only while idle, the block itself does not enforce this.
// camps live in a row of cells, newest at cell 0. a query token walks down
// the row one cell per cycle until a camp is out of reach or the oldest camp
// is passed, then the result walks back to cell 0. S_FIN, reached straight
// from S_IDLE when nothing is stored, loads the result register and shifts
// the row; the next camp is taken in the cycle after the result is loaded.
// reset clears the count (sequence restarts), max_jump and all valids.
// a stalled result holds in the output register; a finished walk waits until
// that register frees up, and no new camp is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_jump_min_cost_dp_unit_defines.svh"

module bounded_jump_min_cost_dp_unit import bjmc_pkg::*; #(
    parameter int unsigned MAX_CAMPS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_max_jump_we,
    input  wire logic [POS_W-1:0]  i_max_jump_wdata,
    input  wire logic              i_camp_valid,
    output logic                   o_camp_stall,
    input  wire logic [POS_W-1:0]  i_camp_position,
    input  wire logic [COST_W-1:0] i_camp_cost,
    input  wire logic              i_is_last_camp,
    output logic                   o_result_valid,
    input  wire logic              i_result_stall,
    output logic [BEST_W-1:0]      o_best_cost,
    output logic                   o_reachable,
    output logic                   o_overflow,
    output logic                   o_is_last_result
);

    localparam int unsigned IDX_W = (MAX_CAMPS > 1) ? $clog2(MAX_CAMPS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_CAMPS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [POS_W-1:0]    r_max_jump;
    logic [POS_W-1:0]    r_pos;
    logic [COST_W-1:0]   r_cost;
    logic                r_last;
    logic                r_base_ok;
    logic [IDX_W-1:0]    r_last_idx;
    logic [BEST_W-1:0]   r_best;
    logic                r_found;

    logic                r_out_valid;
    logic [BEST_W-1:0]   r_out_best;
    logic                r_out_reach;
    logic                r_out_ovf;
    logic                r_out_last;

    logic                w_in_acc;
    logic                w_empty;
    logic                w_base_now;
    logic                w_load;
    logic                w_ovf;
    logic                w_shift;
    logic [BEST_W:0]     w_sum;
    logic [BEST_W-1:0]   w_fin_best;
    t_entry              w_new;

    t_acc                w_tok  [0:MAX_CAMPS];
    t_acc                w_back [0:MAX_CAMPS];
    t_entry              w_ent  [0:MAX_CAMPS-1];

    assign w_in_acc   = i_camp_valid && !o_camp_stall;
    assign w_empty    = (r_cnt == '0);
    assign w_base_now = (i_camp_position <= r_max_jump);
    assign w_ovf      = (r_cnt == CNT_W'(MAX_CAMPS));

    // saturating add of the entry cost
    assign w_sum      = {1'b0, r_best} + (BEST_W + 1)'(r_cost);
    assign w_fin_best = !r_found ? '0 : (w_sum[BEST_W] ? '1 : w_sum[BEST_W-1:0]);
    assign w_shift    = w_load && !w_ovf;
    assign w_new      = '{pos: r_pos, best: w_fin_best, ok: r_found};

    assign w_tok[0]          = '{valid: w_in_acc && !w_empty, best: '0, found: 1'b0};
    assign w_back[MAX_CAMPS] = '0;

    for (genvar g = 0; g < MAX_CAMPS; g++) begin : g_cell
        t_entry w_prev;
        if (g == 0) begin : g_head
            assign w_prev = w_new;
        end else begin : g_body
            assign w_prev = w_ent[g-1];
        end
        bjmc_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pos      (r_pos),
            .i_max_jump (r_max_jump),
            .i_base_ok  (r_base_ok),
            .i_last_idx (r_last_idx),
            .i_shift    (w_shift),
            .i_ent      (w_prev),
            .o_ent      (w_ent[g]),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1]),
            .i_back     (w_back[g+1]),
            .o_back     (w_back[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_camp_stall = (r_state != S_IDLE);
        w_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_empty ? S_FIN : S_WALK;
                end
            end
            S_WALK: begin
                if (w_back[0].valid) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_load = !r_out_valid || !i_result_stall;
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_max_jump  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_max_jump_we) begin
                r_max_jump <= i_max_jump_wdata;
            end
            if (w_load) begin
                r_cnt <= r_last ? '0 : (w_ovf ? r_cnt : r_cnt + CNT_W'(1));
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_result_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pos      <= i_camp_position;
            r_cost     <= i_camp_cost;
            r_last     <= i_is_last_camp;
            r_base_ok  <= w_base_now;
            r_last_idx <= IDX_W'(r_cnt - CNT_W'(1));
            r_best     <= '0;
            r_found    <= w_base_now;
        end else if ((r_state == S_WALK) && w_back[0].valid) begin
            r_best  <= w_back[0].best;
            r_found <= w_back[0].found;
        end
        if (w_load) begin
            r_out_best  <= w_fin_best;
            r_out_reach <= r_found;
            r_out_ovf   <= w_ovf;
            r_out_last  <= r_last;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_best_cost      = r_out_best;
    assign o_reachable      = r_out_reach;
    assign o_overflow       = r_out_ovf;
    assign o_is_last_result = r_out_last;

    `BJMC_ASSERT(a_tok_in_row, i_clk, i_rst_n, !w_tok[MAX_CAMPS].valid)
    `BJMC_ASSERT_IMP(a_back_in_walk, i_clk, i_rst_n, w_back[0].valid, r_state == S_WALK)
    `BJMC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(MAX_CAMPS))
    `BJMC_ASSERT_NXT(a_load_out, i_clk, i_rst_n, w_load, o_result_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bounded jump min cost dp unit. camps stream in
// through a gapped driver; a model of the camp store predicts every result
// and a monitor checks each one against it while the result side stalls at
// random. covers extreme fields, several jump settings and store overflow.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bjmc_pkg::*;

    localparam int unsigned CAMP_CAP     = 1024;
    localparam int unsigned RANDOM_CAMPS = 900;
    localparam int unsigned QUIET_LIMIT  = 20000;
    localparam int unsigned REPORT_MAX   = 10;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [COST_W-1:0] cost;
        logic              last;
    } camp_t;

    typedef struct packed {
        logic [BEST_W-1:0] cost;
        logic              reach;
        logic              ovf;
        logic              last;
    } outcome_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_max_jump_we = 1'b0;
    logic [POS_W-1:0]  i_max_jump_wdata = '0;
    logic              i_camp_valid = 1'b0;
    logic              o_camp_stall;
    logic [POS_W-1:0]  i_camp_position = '0;
    logic [COST_W-1:0] i_camp_cost = '0;
    logic              i_is_last_camp = 1'b0;
    logic              o_result_valid;
    logic              i_result_stall = 1'b0;
    logic [BEST_W-1:0] o_best_cost;
    logic              o_reachable;
    logic              o_overflow;
    logic              o_is_last_result;

    bounded_jump_min_cost_dp_unit #(
        .MAX_CAMPS(CAMP_CAP)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_jump_we   (i_max_jump_we),
        .i_max_jump_wdata(i_max_jump_wdata),
        .i_camp_valid    (i_camp_valid),
        .o_camp_stall    (o_camp_stall),
        .i_camp_position (i_camp_position),
        .i_camp_cost     (i_camp_cost),
        .i_is_last_camp  (i_is_last_camp),
        .o_result_valid  (o_result_valid),
        .i_result_stall  (i_result_stall),
        .o_best_cost     (o_best_cost),
        .o_reachable     (o_reachable),
        .o_overflow      (o_overflow),
        .o_is_last_result(o_is_last_result)
    );

    // model of the camp store
    bit [POS_W-1:0]  reach_limit = '0;
    bit [POS_W-1:0]  camp_pos_mem [CAMP_CAP];
    bit [BEST_W-1:0] camp_best_mem [CAMP_CAP];
    bit              camp_ok_mem [CAMP_CAP];
    int unsigned     stored_camps = 0;

    camp_t       pending[$];
    outcome_t    results_due[$];
    bit          steady = 1'b0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned result_idx = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint wide(bit [31:0] v);
        return longint'({32'h0, v});
    endfunction

    // a camp ahead of the destination has negative distance and is in reach
    function automatic bit within_jump(bit [POS_W-1:0] dest, bit [POS_W-1:0] src);
        return (wide(dest) - wide(src)) <= wide(reach_limit);
    endfunction

    function automatic outcome_t predict_camp(camp_t c);
        outcome_t    r;
        bit          found;
        bit          stopped;
        bit [32:0]   acc;
        int unsigned k;
        found = 1'b0;
        stopped = 1'b0;
        acc = '0;
        k = stored_camps;
        while (k > 0 && !stopped) begin
            if (!within_jump(c.pos, camp_pos_mem[k-1])) begin
                stopped = 1'b1;
            end else begin
                if (camp_ok_mem[k-1] && (!found || {1'b0, camp_best_mem[k-1]} < acc)) begin
                    acc = {1'b0, camp_best_mem[k-1]};
                end
                found = found | camp_ok_mem[k-1];
            end
            k = k - 1;
        end
        // implied base camp at position 0 with cost 0
        if (!stopped && within_jump(c.pos, '0)) begin
            acc = '0;
            found = 1'b1;
        end
        if (found) begin
            acc = acc + c.cost;
            if (acc[32]) begin
                acc = 33'h0_FFFF_FFFF;
            end
        end else begin
            acc = '0;
        end
        r.cost = acc[31:0];
        r.reach = found;
        r.ovf = (stored_camps >= CAMP_CAP);
        r.last = c.last;
        if (!r.ovf) begin
            camp_pos_mem[stored_camps] = c.pos;
            camp_best_mem[stored_camps] = acc[31:0];
            camp_ok_mem[stored_camps] = found;
            stored_camps = stored_camps + 1;
        end
        if (c.last) begin
            stored_camps = 0;
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while steady
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(3, 1);
        end else if (r < 98) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    function automatic void queue_camp(bit [POS_W-1:0] pos, bit [COST_W-1:0] cost, bit last);
        camp_t c;
        c.pos = pos;
        c.cost = cost;
        c.last = last;
        pending = {pending, c};
    endfunction

    // mostly well-formed sequences, some noisy positions, some left unclosed
    function automatic int unsigned queue_sequence();
        int unsigned n;
        int unsigned r;
        bit          closed;
        longint      at;
        bit [15:0]   cost;
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        closed = ($urandom_range(9, 0) != 0);
        at = ($urandom_range(3, 0) == 0) ? wide($urandom) : wide($urandom_range(reach_limit, 0));
        for (int unsigned i = 0; i < n; i++) begin
            if (i != 0) begin
                r = $urandom_range(99, 0);
                if (r < 15) begin
                    at = at;
                end else if (r < 65) begin
                    at = at + wide($urandom_range(reach_limit, 0));
                end else if (r < 85) begin
                    at = at + wide(reach_limit) + 1 + wide($urandom_range(reach_limit, 0));
                end else if (r < 93) begin
                    at = wide($urandom);
                end else begin
                    at = at - wide($urandom_range(1000, 1));
                end
                if (at < 0) begin
                    at = 0;
                end else if (at > wide(32'hFFFF_FFFF)) begin
                    at = wide(32'hFFFF_FFFF);
                end
            end
            r = $urandom_range(9, 0);
            cost = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
            queue_camp(at[31:0], cost, closed && (i == n - 1));
        end
        return n;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending.size() != 0 || i_camp_valid || results_due.size() != 0) begin
            @(negedge i_clk);
        end
        // let the insert of the last camp settle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_jump(bit [POS_W-1:0] v);
        @(posedge i_clk);
        i_max_jump_we <= 1'b1;
        i_max_jump_wdata <= v;
        @(posedge i_clk);
        i_max_jump_we <= 1'b0;
        reach_limit = v;
    endtask

    // camp driver
    always @(posedge i_clk) begin
        logic  nxt_valid;
        camp_t c;
        if (!i_rst_n) begin
            i_camp_valid <= 1'b0;
        end else begin
            nxt_valid = i_camp_valid;
            if (i_camp_valid && !o_camp_stall) begin
                results_due = {results_due, predict_camp({i_camp_position, i_camp_cost,
                                                          i_is_last_camp})};
                nxt_valid = 1'b0;
                send_gap = pick_gap();
            end
            if (!nxt_valid) begin
                if (send_gap != 0) begin
                    send_gap = send_gap - 1;
                end else if (pending.size() != 0) begin
                    c = pending.pop_front();
                    i_camp_position <= c.pos;
                    i_camp_cost <= c.cost;
                    i_is_last_camp <= c.last;
                    nxt_valid = 1'b1;
                end
            end
            i_camp_valid <= nxt_valid;
        end
    end

    // result monitor and stall generator
    always @(posedge i_clk) begin
        outcome_t got;
        outcome_t want;
        if (i_rst_n) begin
            if (o_result_valid && !i_result_stall) begin
                got = {o_best_cost, o_reachable, o_overflow, o_is_last_result};
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("result %0d: unexpected transaction cost %h reach %b ovf %b last %b",
                                 result_idx, got.cost, got.reach, got.ovf, got.last);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (got.cost !== want.cost || got.reach !== want.reach ||
                        got.ovf !== want.ovf || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("result %0d: expected cost %h reach %b ovf %b last %b",
                                     result_idx, want.cost, want.reach, want.ovf, want.last);
                            $display("result %0d: actual   cost %h reach %b ovf %b last %b",
                                     result_idx, got.cost, got.reach, got.ovf, got.last);
                        end
                    end
                end
                result_idx++;
            end
            if (hold_left != 0) begin
                i_result_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_result_stall <= 1'b0;
                hold_left = pick_gap();
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_camp_valid && !o_camp_stall) || (o_result_valid && !i_result_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned sent;
        int unsigned r;
        bit [POS_W-1:0] j;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // jump of zero from reset: equal positions reach, unreachable camps skipped,
        // a step backward still in reach
        queue_camp(32'h0000_0000, 16'hFFFF, 1'b0);
        queue_camp(32'h0000_0000, 16'h0000, 1'b0);
        queue_camp(32'h0000_0001, 16'h0007, 1'b0);
        queue_camp(32'h0000_0001, 16'h0003, 1'b0);
        queue_camp(32'h0000_0000, 16'h0009, 1'b1);
        wait_drained();

        write_jump(32'hFFFF_FFFF);
        queue_camp(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_camp(32'hFFFF_FFFF, 16'h0001, 1'b0);
        queue_camp(32'h0000_0000, 16'hAAAA, 1'b0);
        queue_camp(32'h5555_5555, 16'h5555, 1'b1);
        wait_drained();

        write_jump(32'd10);
        queue_camp(32'h7FFF_FFFF, 16'h0001, 1'b0);
        queue_camp(32'd5, 16'h0002, 1'b0);
        queue_camp(32'd12, 16'h0004, 1'b0);
        queue_camp(32'd30, 16'h0001, 1'b0);
        queue_camp(32'd40, 16'h0008, 1'b0);
        queue_camp(32'd40, 16'h0003, 1'b1);
        queue_camp(32'd3, 16'h1234, 1'b1);
        queue_camp(32'd11, 16'h00FF, 1'b1);
        wait_drained();

        write_jump(32'hAAAA_AAAA);
        queue_camp(32'hAAAA_AAAA, 16'h8000, 1'b0);
        queue_camp(32'hAAAA_AAAB, 16'h7FFF, 1'b0);
        queue_camp(32'hFFFF_FFFF, 16'h0001, 1'b1);
        wait_drained();
        write_jump(32'h5555_5555);

        sent = 0;
        while (sent < RANDOM_CAMPS) begin
            r = $urandom_range(5, 0);
            case (r)
                0: j = '0;
                1: j = $urandom_range(16, 1);
                2: j = $urandom_range(5000, 17);
                3: j = $urandom;
                4: j = 32'hFFFF_FFFF;
                default: j = $urandom_range(64, 1);
            endcase
            write_jump(j);
            steady = ($urandom_range(3, 0) == 0);
            repeat ($urandom_range(8, 3)) begin
                sent += queue_sequence();
            end
            wait_drained();
        end

        // fill the store past its capacity with short windows, then walk all of it
        steady = 1'b0;
        queue_camp(32'd0, 16'd0, 1'b1);
        wait_drained();
        write_jump(32'd5);
        for (int unsigned i = 0; i < CAMP_CAP + 6; i++) begin
            queue_camp(32'(5 * (i + 1)), 16'($urandom), 1'b0);
        end
        wait_drained();
        write_jump(32'hFFFF_FFFF);
        queue_camp($urandom, 16'($urandom), 1'b1);
        wait_drained();
        queue_camp(32'd1, 16'd1, 1'b1);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
